@@ rtl/swti_pkg.sv @@
`default_nettype none
package swti_pkg;

  localparam int POS_W = 7;
  localparam int MAC_PAIR_BYTES = 12;
  localparam int TAG_BYTES = 4;
  localparam int HDR_BYTES = MAC_PAIR_BYTES + TAG_BYTES;
  localparam int POS_SAT = 64;
  localparam int PAE_BYTES = 6;
  localparam int SUB_W = $clog2(TAG_BYTES + 1);
  localparam int STORE_IDX_W = $clog2(MAC_PAIR_BYTES);

  localparam logic [11:0] VLAN_BASE_RST = 12'd4071;
  localparam logic [4:0] PORT_MASK = 5'h1f;
  localparam logic [15:0] TCI_FLAG = 16'h1000;
  localparam logic [7:0] TPID_HI = 8'h81;
  localparam logic [7:0] TPID_LO = 8'h00;

  localparam logic [7:0] PAE_GROUP [PAE_BYTES] = '{8'h01, 8'h80, 8'hC2, 8'h00, 8'h00, 8'h03};

  typedef enum logic [2:0] {
    CMD_TX,
    CMD_RX_STORE,
    CMD_RX_PASS,
    CMD_RX_FLUSH,
    CMD_DROP
  } cmd_kind_t;

  // One classified input byte, handed from front to back.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic             last;
    logic             pae;
    logic [15:0]      tci;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/swti_front.sv @@
`default_nettype none
module swti_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [11:0]        cfg_wr_data,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // in_byte
  input  wire logic               s_axis_tuser,  // action
  input  wire logic               s_axis_tlast,  // frame_last
  input  wire logic               q_full,
  output logic                    push,
  output swti_pkg::cmd_t          push_cmd
);
  import swti_pkg::*;

  logic [11:0]      vlan_base;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             frame_direction;
  logic             drop_pending;
  logic             drop_pending_next;
  logic             pae_match;
  logic             tag_bad;
  logic             accept;
  logic             dir;
  logic [15:0]      tci;

  assign s_axis_tready = !q_full;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign dir = (pos == '0) ? s_axis_tuser : frame_direction;
  assign tci = ({4'd0, vlan_base} + {11'd0, s_axis_tdata[4:0] & PORT_MASK}) | TCI_FLAG;

  always_comb begin
    push = 1'b0;
    drop_pending_next = drop_pending;
    push_cmd.kind = CMD_TX;
    push_cmd.pos = pos;
    push_cmd.data = s_axis_tdata;
    push_cmd.last = s_axis_tlast;
    push_cmd.pae = pae_match;
    push_cmd.tci = tci;
    if (!dir) begin
      push = 1'b1;
    end else if (drop_pending) begin
      push_cmd.kind = CMD_DROP;
      push = s_axis_tlast;
    end else if (pos < POS_W'(MAC_PAIR_BYTES)) begin
      // a frame ending inside the MAC pair is too short: no need to store
      push_cmd.kind = s_axis_tlast ? CMD_DROP : CMD_RX_STORE;
      push = 1'b1;
    end else if (pos < POS_W'(HDR_BYTES - 1)) begin
      push_cmd.kind = CMD_DROP;
      push = s_axis_tlast;
    end else if (pos == POS_W'(HDR_BYTES - 1)) begin
      if (tag_bad) begin
        push_cmd.kind = CMD_DROP;
        push = s_axis_tlast;
        drop_pending_next = !s_axis_tlast;
      end else begin
        push_cmd.kind = CMD_RX_FLUSH;
        push = 1'b1;
      end
    end else begin
      push_cmd.kind = CMD_RX_PASS;
      push = 1'b1;
    end
    if (!accept) begin
      push = 1'b0;
      drop_pending_next = drop_pending;
    end else if (s_axis_tlast) begin
      drop_pending_next = 1'b0;
    end
  end

  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (s_axis_tlast) begin
        pos_next = '0;
      end else if (pos < POS_W'(POS_SAT)) begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_base <= VLAN_BASE_RST;
      pos <= '0;
      frame_direction <= 1'b0;
      drop_pending <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vlan_base <= cfg_wr_data;
      end
      pos <= pos_next;
      drop_pending <= drop_pending_next;
      if (accept && pos == '0) begin
        frame_direction <= s_axis_tuser;
      end
    end
  end

  // group address match and tag check built up as the header streams in
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == '0) begin
        pae_match <= (s_axis_tdata == PAE_GROUP[0]);
      end else if (pos < POS_W'(PAE_BYTES)) begin
        pae_match <= pae_match && (s_axis_tdata == PAE_GROUP[pos[2:0]]);
      end
      if (pos == POS_W'(MAC_PAIR_BYTES)) begin
        tag_bad <= |s_axis_tdata;
      end else if (pos == POS_W'(MAC_PAIR_BYTES + 1)) begin
        tag_bad <= tag_bad || (|s_axis_tdata);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/swti_cmd_fifo.sv @@
`default_nettype none
module swti_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire swti_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                q_valid,
  output swti_pkg::cmd_t      head
);
  import swti_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command pushed into full queue");

endmodule
`default_nettype wire

@@ rtl/swti_back.sv @@
`default_nettype none
module swti_back #(
  parameter int MIN_FRAME_BYTES = 60
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire swti_pkg::cmd_t head,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // out_byte
  output logic                m_axis_tlast,  // out_frame_end
  output logic [1:0]          m_axis_tuser   // [0] frame_dropped, [1] run_last
);
  import swti_pkg::*;

  localparam logic [POS_W-1:0] PAD_END = POS_W'(MIN_FRAME_BYTES - 1);

  logic [7:0]       hdr [MAC_PAIR_BYTES];
  logic             active;
  logic [POS_W-1:0] idx;
  logic [SUB_W-1:0] sub;
  logic [POS_W-1:0] cur_i;
  logic [SUB_W-1:0] cur_sub;
  logic [POS_W-1:0] tx_end;
  logic [POS_W-1:0] flush_end;
  logic             load_ok;
  logic             emit;
  logic             final_res;
  logic             in_tag;
  logic [7:0]       res_byte;
  logic             res_drop;
  logic [7:0]       tag_byte;

  assign load_ok = !m_axis_tvalid || m_axis_tready;
  assign cur_i = active ? idx : ((head.kind == CMD_TX) ? head.pos : '0);
  assign cur_sub = active ? sub : '0;
  assign tx_end = (head.last && head.pos < PAD_END) ? PAD_END : head.pos;
  assign flush_end = head.pae ? POS_W'(HDR_BYTES - 1) : POS_W'(MAC_PAIR_BYTES - 1);

  always_comb begin
    unique case (cur_i[1:0])
      2'd0: tag_byte = TPID_HI;
      2'd1: tag_byte = TPID_LO;
      2'd2: tag_byte = head.tci[15:8];
      2'd3: tag_byte = head.tci[7:0];
      default: tag_byte = '0;
    endcase
  end

  always_comb begin
    res_byte = '0;
    res_drop = 1'b0;
    final_res = 1'b1;
    in_tag = 1'b0;
    unique case (head.kind)
      CMD_TX: begin
        if (cur_i == POS_W'(MAC_PAIR_BYTES) && cur_sub < SUB_W'(TAG_BYTES)) begin
          in_tag = 1'b1;
          final_res = 1'b0;
        end else begin
          res_byte = (cur_i == head.pos) ? head.data : 8'd0;
          final_res = (cur_i == tx_end);
        end
      end
      CMD_RX_FLUSH: begin
        res_byte = (cur_i < POS_W'(MAC_PAIR_BYTES)) ? hdr[cur_i[STORE_IDX_W-1:0]] : tag_byte;
        final_res = (cur_i == flush_end);
      end
      CMD_RX_PASS: res_byte = head.data;
      CMD_DROP: res_drop = 1'b1;
      CMD_RX_STORE: final_res = 1'b1;
      default: final_res = 1'b1;
    endcase
  end

  assign emit = q_valid && head.kind != CMD_RX_STORE && load_ok;
  assign pop = (q_valid && head.kind == CMD_RX_STORE) || (emit && final_res);

  always_ff @(posedge clk) begin
    if (q_valid && head.kind == CMD_RX_STORE) begin
      hdr[head.pos[STORE_IDX_W-1:0]] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b0;
      end else if (emit) begin
        active <= 1'b1;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= res_byte;
      m_axis_tlast <= final_res && head.last;
      m_axis_tuser <= {final_res, res_drop};
      if (in_tag) begin
        idx <= cur_i;
        sub <= cur_sub + 1'b1;
      end else begin
        idx <= cur_i + 1'b1;
        sub <= '0;
      end
    end
  end

  a_active_has_cmd: assert property (@(posedge clk) disable iff (rst) active |-> q_valid)
    else $error("expansion in progress with empty queue");
  a_drop_notice: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1] && m_axis_tdata == 8'd0)
    else $error("malformed drop notice");
  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("frame end not on last result of its request");

endmodule
`default_nettype wire

@@ rtl/switch_tag_insert_strip.sv @@
`default_nettype none
// Channel  | Signals                        | Contents (low bit first)
// s_axis   | tvalid tready tdata tuser tlast| tdata in_byte, tuser action, tlast frame_last
// m_axis   | tvalid tready tdata tuser tlast| tdata out_byte, tuser frame_dropped,run_last,
//          |                                | tlast out_frame_end
// cfg      | cfg_wr_en cfg_wr_data          | eapol_vlan_base, 12 bits
//
// Input side takes one byte per cycle while the command queue has room.
// Output side gives one result per cycle while m_axis_tready holds; a transmit byte
// at position 12 expands to 5 results, a short transmit frame's last byte to up to
// 60+4, a receive byte 15 to 12 or 16; the back end's expansion counter sets that figure.
// Receive bytes 0..14 and swallowed bytes give no result, bar a drop notice on frame_last.
// rst is synchronous: clears position, direction, drop flag, queue and output.
// Either side may stall; the queue and output register decouple them.
module switch_tag_insert_strip #(
  parameter int MIN_FRAME_BYTES = 60,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,   // eapol_vlan_base
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  wire logic        s_axis_tuser,  // [0] action
  input  wire logic        s_axis_tlast,  // frame_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]       m_axis_tuser,  // [0] frame_dropped, [1] run_last
  output logic             m_axis_tlast   // out_frame_end
);
  import swti_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t head;

  swti_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  swti_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  swti_back #(
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

@@ dv/tag_frame_checker.sv @@
module tag_frame_checker
  import swti_pkg::*;
#(
  parameter int MIN_FRAME_BYTES = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] action
  input  logic        s_axis_tlast,   // frame_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic [1:0]  m_axis_tuser,   // [0] frame_dropped, [1] run_last
  input  logic        m_axis_tlast,   // out_frame_end
  output int          mismatch_count,
  output int          results_due
);

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       dropped;
    logic       run_last;
  } frame_out_t;

  frame_out_t  due_out[$];

  logic [6:0]  byte_pos;
  logic        rx_frame;
  logic        swallowing;
  logic [11:0] vlan_base;
  logic [7:0]  hdr_bytes[HDR_BYTES];

  initial begin
    mismatch_count = 0;
    results_due = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_out(input logic [7:0] data, input logic dropped);
    frame_out_t item;
    item = '{data: data, frame_end: 1'b0, dropped: dropped, run_last: 1'b0};
    due_out.push_back(item);
  endtask

  // tag goes in just ahead of byte 12, zeros
  task automatic push_tx(input int pos, input logic [7:0] data);
    if (pos == MAC_PAIR_BYTES) begin
      repeat (TAG_BYTES) push_out(8'h00, 1'b0);
    end
    push_out(data, 1'b0);
  endtask

  task automatic predict_tag_edit(input logic action, input logic [7:0] data,
                                  input logic last);
    int          pos;
    int          first_new;
    bit          is_pae;
    logic [15:0] tci;
    frame_out_t  tail;
    pos = byte_pos;
    first_new = due_out.size();
    if (pos == 0) begin
      rx_frame = action;
    end
    if (!rx_frame) begin
      push_tx(pos, data);
      if (last) begin
        // pad short frames; padding also sees the tag insertion
        for (int i = pos + 1; i < MIN_FRAME_BYTES; i++) begin
          push_tx(i, 8'h00);
        end
      end
    end else if (swallowing) begin
      if (last) begin
        push_out(8'h00, 1'b1);
      end
    end else if (pos < HDR_BYTES) begin
      hdr_bytes[pos] = data;
      if (pos == HDR_BYTES - 1) begin
        if (hdr_bytes[MAC_PAIR_BYTES] != 8'h00 || hdr_bytes[MAC_PAIR_BYTES + 1] != 8'h00) begin
          if (last) begin
            push_out(8'h00, 1'b1);
          end else begin
            swallowing = 1'b1;
          end
        end else begin
          for (int i = 0; i < MAC_PAIR_BYTES; i++) begin
            push_out(hdr_bytes[i], 1'b0);
          end
          is_pae = 1'b1;
          for (int i = 0; i < PAE_BYTES; i++) begin
            if (hdr_bytes[i] != PAE_GROUP[i]) begin
              is_pae = 1'b0;
            end
          end
          if (is_pae) begin
            // 16-bit sum: a base near the top carries into the CFI bit
            tci = 16'(vlan_base) + 16'(hdr_bytes[HDR_BYTES - 1][4:0] & PORT_MASK);
            tci = tci | TCI_FLAG;
            push_out(TPID_HI, 1'b0);
            push_out(TPID_LO, 1'b0);
            push_out(tci[15:8], 1'b0);
            push_out(tci[7:0], 1'b0);
          end
        end
      end else if (last) begin
        push_out(8'h00, 1'b1);
      end
    end else begin
      push_out(data, 1'b0);
    end

    if (due_out.size() > first_new) begin
      tail = due_out.pop_back();
      tail.frame_end = last;
      tail.run_last = 1'b1;
      due_out.push_back(tail);
    end

    if (last) begin
      byte_pos = '0;
      swallowing = 1'b0;
    end else if (pos < POS_SAT) begin
      byte_pos = 7'(pos + 1);
    end
  endtask

  task automatic check_out();
    frame_out_t want;
    if (due_out.size() == 0) begin
      report_mismatch("unexpected result", int'(m_axis_tdata), 0);
    end else begin
      want = due_out.pop_front();
      if (m_axis_tdata !== want.data) begin
        report_mismatch("out_byte", int'(m_axis_tdata), int'(want.data));
      end
      if (m_axis_tlast !== want.frame_end) begin
        report_mismatch("out_frame_end", int'(m_axis_tlast), int'(want.frame_end));
      end
      if (m_axis_tuser[0] !== want.dropped) begin
        report_mismatch("frame_dropped", int'(m_axis_tuser[0]), int'(want.dropped));
      end
      if (m_axis_tuser[1] !== want.run_last) begin
        report_mismatch("run_last", int'(m_axis_tuser[1]), int'(want.run_last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_pos = '0;
      rx_frame = 1'b0;
      swallowing = 1'b0;
      vlan_base = VLAN_BASE_RST;
      due_out.delete();
    end else begin
      if (cfg_wr_en) begin
        vlan_base = cfg_wr_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tag_edit(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_out();
      end
    end
    results_due <= due_out.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench;
  import swti_pkg::*;

  localparam int MIN_FRAME_BYTES = 60;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_BYTES = 50;
  localparam int NUM_PHASES = 6;
  localparam logic ACT_TX = 1'b0;
  localparam logic ACT_RX = 1'b1;

  typedef enum int {
    RX_PLAIN,
    RX_PAE,
    RX_BAD_TAG,
    RX_NOISE
  } rx_hdr_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;   // [0] action
  logic        s_axis_tlast = 1'b0;   // frame_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [7:0] out_byte
  logic [1:0]  m_axis_tuser;          // [0] frame_dropped, [1] run_last
  logic        m_axis_tlast;          // out_frame_end

  int          mismatch_count;
  int          results_due;
  int          bytes_sent = 0;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;
  logic [7:0]  frame_buf[$];

  always #1 clk = ~clk;

  switch_tag_insert_strip #(
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  tag_frame_checker #(
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  // result sink: random stall ahead of each result while recv_stalls is set
  initial begin
    int stall;
    forever begin
      stall = recv_stalls ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic action, input logic [7:0] data, input logic last);
    int gap;
    gap = send_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= action;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // mid-frame action flips must be ignored by the block
  task automatic send_frame(input logic action, input bit flip_action);
    logic this_act;
    for (int i = 0; i < frame_buf.size(); i++) begin
      this_act = (i > 0 && flip_action) ? 1'($urandom_range(0, 1)) : action;
      send_byte(this_act, frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic fill_random(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_rx_frame(input int len, input rx_hdr_kind_t kind);
    int pick;
    fill_random(len);
    if (kind != RX_NOISE) begin
      if (kind == RX_PAE || (kind == RX_PLAIN && $urandom_range(0, 3) == 0)) begin
        for (int i = 0; i < PAE_BYTES && i < len; i++) begin
          frame_buf[i] = PAE_GROUP[i];
        end
        // near miss on the group address
        if (kind == RX_PLAIN) begin
          pick = $urandom_range(0, PAE_BYTES - 1);
          if (pick < len) begin
            frame_buf[pick] = frame_buf[pick] ^ 8'($urandom_range(1, 255));
          end
        end
      end
      if (len > MAC_PAIR_BYTES) begin
        frame_buf[MAC_PAIR_BYTES] = 8'h00;
      end
      if (len > MAC_PAIR_BYTES + 1) begin
        frame_buf[MAC_PAIR_BYTES + 1] = 8'h00;
      end
      if (kind == RX_BAD_TAG) begin
        pick = $urandom_range(0, 2);
        if (pick != 1 && len > MAC_PAIR_BYTES) begin
          frame_buf[MAC_PAIR_BYTES] = 8'($urandom_range(1, 255));
        end
        if (pick != 0 && len > MAC_PAIR_BYTES + 1) begin
          frame_buf[MAC_PAIR_BYTES + 1] = 8'($urandom_range(1, 255));
        end
      end
    end
  endtask

  task automatic send_random_frame();
    int           roll;
    int           len;
    logic         action;
    rx_hdr_kind_t kind;
    action = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (action == ACT_TX) begin
      if (roll < 80) begin
        len = $urandom_range(1, 20);
      end else if (roll < 92) begin
        len = $urandom_range(55, 62);
      end else begin
        len = $urandom_range(63, 70);
      end
      fill_random(len);
    end else begin
      if (roll < 15) begin
        len = $urandom_range(1, HDR_BYTES - 1);
      end else if (roll < 90) begin
        len = $urandom_range(HDR_BYTES, 24);
      end else begin
        len = $urandom_range(60, 70);
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        kind = RX_PLAIN;
      end else if (roll < 70) begin
        kind = RX_PAE;
      end else if (roll < 90) begin
        kind = RX_BAD_TAG;
      end else begin
        kind = RX_NOISE;
      end
      build_rx_frame(len, kind);
    end
    send_frame(action, $urandom_range(0, 99) < 15);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_vlan_base(input logic [11:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int          target;
    int          frames_in_phase;
    logic [11:0] base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-byte transmit: padded out to min size, tag included
    frame_buf = '{8'hFF};
    send_frame(ACT_TX, 1'b0);
    // runt receive frame
    frame_buf = '{8'hA5};
    send_frame(ACT_RX, 1'b0);
    // EAPOL frame ending on the last header byte, port bits all set
    build_rx_frame(HDR_BYTES, RX_PAE);
    frame_buf[MAC_PAIR_BYTES + 2] = 8'hFF;
    frame_buf[MAC_PAIR_BYTES + 3] = 8'hFF;
    send_frame(ACT_RX, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (ph)
          1: begin
            base = 12'd0;
          end
          2: begin
            base = 12'hFFF;
          end
          3: begin
            base = 12'd4064;
          end
          4: begin
            base = 12'($urandom_range(0, 4095));
          end
          default: begin
            base = 12'd1;
          end
        endcase
        write_vlan_base(base);
      end
      send_gaps = !(ph == 1 || ph == 3);
      recv_stalls = !(ph == 2 || ph == 3);
      target = bytes_sent + PHASE_BYTES;
      frames_in_phase = 0;
      while (bytes_sent < target) begin
        send_random_frame();
        frames_in_phase++;
        // hold off until the output side has caught up
        if (ph == 2 && frames_in_phase == 2) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
